// File: hdl/ppfs_pkg.sv
// Shared types and constants for the physical page free stack.
// Request and result beat structs, request and status codes, and the
// command and status structs between controller and datapath.
`timescale 1ns / 1ps

package ppfs_pkg;

    // Fixed field widths of the request and result beats
    localparam int ADDR_W    = 48;
    localparam int LEN_W     = 49;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 17;

    // Default configuration
    localparam int DEF_MAX_PAGES  = 65536;
    localparam int DEF_PAGE_SHIFT = 12;
    localparam int DEF_ADDR_BITS  = 48;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_BEGIN  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FINISH = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PHASE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  region_length;
        logic              region_usable;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_W-1:0]    page_address;
        logic [CNT_OUT_W-1:0] free_count;
        logic [CNT_OUT_W-1:0] total_count;
        logic [CNT_OUT_W-1:0] used_count;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the request beat
        logic exec;    // run a single-step request and register its result
        logic calc;    // compute first page and raw end page of a region
        logic clamp;   // clamp region bounds to the address space and page one
        logic push;    // push one region page
        logic finish;  // register the result of a region load
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_region;  // captured request is a usable region during loading
        logic push_more;  // region pages left and room on the stack
    } t_sts;

endpackage

// File: hdl/ppfs_dp.sv
// Datapath of the physical page free stack: stack memory, counters,
// phase flags, region walker and result register. Depends on ppfs_pkg.
`timescale 1ns / 1ps

module ppfs_dp import ppfs_pkg::*; #(
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_result
);

    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int SW     = ADDR_W - PAGE_SHIFT;
    localparam int SUM_W  = ADDR_W + 2;
    localparam int PN_W   = SUM_W - PAGE_SHIFT;
    localparam int LIM_SH = (ADDR_BITS > PAGE_SHIFT) ? (ADDR_BITS - PAGE_SHIFT) : 0;
    localparam int EXT_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    localparam logic [ADDR_W-1:0] AMASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
        ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [ADDR_W-1:0] LOW_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_PAGES);
    localparam logic [PN_W-1:0]   PN_ONE   = PN_W'(1);

    // Stack memory of page numbers
    logic [SW-1:0] r_stack [MAX_PAGES];
    logic [SW-1:0] r_rd_data;

    logic [CNT_W-1:0] r_top, n_top;
    logic [CNT_W-1:0] r_total, n_total;
    logic             r_ready, n_ready;
    logic             r_loading, n_loading;
    logic [PN_W-1:0]  r_cur, n_cur;
    logic [PN_W-1:0]  r_end, n_end;
    t_req             r_req;
    t_rsp             r_result, n_result;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [SW-1:0]     wr_data;
    logic [IDX_W-1:0]  rd_idx;
    logic [SUM_W-1:0]  region_sum;
    logic              more_pages;
    logic              room_left;
    logic              emit;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0] page;
    logic [CNT_W-1:0]  used;
    logic [EXT_W-1:0]  top_ext;
    logic [EXT_W-1:0]  total_ext;
    logic [EXT_W-1:0]  used_ext;

    // Read the current top entry every cycle so an allocate finds it registered
    assign rd_idx = (r_top == '0) ? '0 : IDX_W'(r_top - CNT_W'(1));

    assign region_sum = {2'b00, r_req.address} + {1'b0, r_req.region_length};
    assign more_pages = (r_cur < r_end);
    assign room_left  = (r_top < MAX_CNT);

    assign o_sts.is_region = (r_req.req_type == REQ_ADD) && r_loading && r_req.region_usable;
    assign o_sts.push_more = more_pages && room_left;

    // Next state of counters, flags, region walker and stack write
    always_comb begin
        n_top     = r_top;
        n_total   = r_total;
        n_ready   = r_ready;
        n_loading = r_loading;
        n_cur     = r_cur;
        n_end     = r_end;
        wr_en     = 1'b0;
        wr_idx    = r_top[IDX_W-1:0];
        wr_data   = r_cur[SW-1:0];
        status    = ST_OK;
        page      = '0;
        emit      = 1'b0;

        if (i_cmd.calc) begin
            n_cur = PN_W'(r_req.address >> PAGE_SHIFT)
                  + PN_W'(|(r_req.address & LOW_MASK));
            n_end = PN_W'(region_sum >> PAGE_SHIFT);
        end

        if (i_cmd.clamp) begin
            if ((r_end >> LIM_SH) != '0) begin
                n_end = PN_ONE << LIM_SH;
            end
            if (r_cur == '0) begin
                n_cur = PN_ONE;
            end
        end

        if (i_cmd.push) begin
            wr_en   = 1'b1;
            n_top   = r_top + CNT_W'(1);
            n_total = r_total + CNT_W'(1);
            n_cur   = r_cur + PN_ONE;
        end

        if (i_cmd.finish) begin
            emit   = 1'b1;
            status = more_pages ? ST_FULL : ST_OK;
        end

        if (i_cmd.exec) begin
            emit = 1'b1;
            unique case (r_req.req_type)
                REQ_BEGIN: begin
                    n_top     = '0;
                    n_total   = '0;
                    n_ready   = 1'b0;
                    n_loading = 1'b1;
                end
                REQ_ADD: begin
                    if (!r_loading) begin
                        status = ST_PHASE;
                    end
                end
                REQ_FINISH: begin
                    if (!r_loading) begin
                        status = ST_PHASE;
                    end else begin
                        n_loading = 1'b0;
                        n_ready   = 1'b1;
                    end
                end
                REQ_ALLOC: begin
                    if (!r_ready) begin
                        status = ST_PHASE;
                    end else if (r_top == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        n_top = r_top - CNT_W'(1);
                        page  = {r_rd_data, {PAGE_SHIFT{1'b0}}} & AMASK;
                    end
                end
                REQ_FREE: begin
                    if (!r_ready) begin
                        status = ST_PHASE;
                    end else if (r_req.address == '0 || (r_req.address & LOW_MASK) != '0
                                 || (r_req.address & ~AMASK) != '0) begin
                        status = ST_BAD;
                    end else if (!room_left) begin
                        status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = SW'(r_req.address >> PAGE_SHIFT);
                        n_top   = r_top + CNT_W'(1);
                    end
                end
                default: begin
                    status = ST_PHASE;
                end
            endcase
        end
    end

    // Assemble the result beat from the counts after the request
    always_comb begin
        used      = (n_total > n_top) ? (n_total - n_top) : '0;
        top_ext   = EXT_W'(n_top);
        total_ext = EXT_W'(n_total);
        used_ext  = EXT_W'(used);
        n_result  = r_result;
        if (emit) begin
            n_result.status       = status;
            n_result.page_address = page;
            n_result.free_count   = top_ext[CNT_OUT_W-1:0];
            n_result.total_count  = total_ext[CNT_OUT_W-1:0];
            n_result.used_count   = used_ext[CNT_OUT_W-1:0];
        end
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_idx] <= wr_data;
        end
        r_rd_data <= r_stack[rd_idx];
    end

    // Control state: counts and phase flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= '0;
            r_total   <= '0;
            r_ready   <= 1'b0;
            r_loading <= 1'b0;
        end else begin
            r_top     <= n_top;
            r_total   <= n_total;
            r_ready   <= n_ready;
            r_loading <= n_loading;
        end
    end

    // Payload: captured request, region bounds, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        r_cur    <= n_cur;
        r_end    <= n_end;
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

// File: hdl/ppfs_ctrl.sv
// Controller of the physical page free stack: sequences each request
// through the datapath and drives busy and the result strobe. Depends on ppfs_pkg.
`timescale 1ns / 1ps

module ppfs_ctrl import ppfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CLAMP = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;

    // Decode state into datapath commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_region) begin
                    o_cmd.calc = 1'b1;
                    n_state    = S_CLAMP;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                if (i_sts.push_more) begin
                    o_cmd.push = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// File: hdl/physical_page_free_stack.sv
// Physical page free stack: LIFO allocator of physical page frames.
// Request beat i_req is accepted when start is high and busy is low.
// Result beat o_result is shown for one cycle with o_valid high; the
// receiver takes it in that cycle and cannot hold it off.
// Begin, finish, allocate, free, an unusable region and any rejected
// request go through the execution step and back to idle; the
// result appears the cycle after the accept's execution step.
// A usable region during loading walks its pages one per cycle through
// the single stack write port, after the calculate and clamp steps.
// Allocate reads the top entry through the registered read port, which
// samples the current top every cycle, so it needs no separate read step.
// Synchronous active-low reset empties the counts and closes both loading
// and service; no memory clearing pass is run, stack entries above the
// top are never returned. The next request may be issued while the
// previous result is still on the output.
// Depends on ppfs_pkg, ppfs_ctrl and ppfs_dp.
`timescale 1ns / 1ps

module physical_page_free_stack import ppfs_pkg::*; #(
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_result
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    ppfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Stack, counters and region walker
    ppfs_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule
